// File: src/sbck_pkg.sv
package sbck_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned SCR_W   = 9;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;

  localparam logic [COLOR_W-1:0] KEY_RESET = 16'd17289;

  typedef enum logic [IDX_W-1:0] {
    REG_X_ORIGIN      = 3'd0,
    REG_Y_ORIGIN      = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_KEY_COLOR     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic               write_enable;
    logic [SCR_W-1:0]   screen_x;
    logic [SCR_W-1:0]   screen_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               sprite_done;
  } result_t;

  typedef struct packed {
    logic col_last;
    logic row_last;
  } step_t;

endpackage

// File: src/sbck_pixel.sv
module sbck_pixel #(
  parameter int SCREEN_COLS    = 480,
  parameter int SCREEN_ROWS    = 320,
  parameter int MAX_SPRITE_DIM = 512,
  localparam int CW = $clog2(MAX_SPRITE_DIM),
  localparam int SW = ((CW > sbck_pkg::COORD_W) ? CW : sbck_pkg::COORD_W) + 2
) (
  input  sbck_pkg::pixel_t                   pixel,
  input  logic signed [sbck_pkg::COORD_W-1:0] x_origin,
  input  logic signed [sbck_pkg::COORD_W-1:0] y_origin,
  input  logic [sbck_pkg::DIM_W-1:0]         sprite_width,
  input  logic [sbck_pkg::DIM_W-1:0]         sprite_height,
  input  logic [sbck_pkg::COLOR_W-1:0]       key_color,
  input  logic [CW-1:0]                      column_count,
  input  logic [CW-1:0]                      row_count,
  output sbck_pkg::result_t                  result,
  output sbck_pkg::step_t                    step
);

  // Last index of a dimension: zero acts as one, oversize clamps to the maximum.
  function automatic logic [CW-1:0] last_index(input logic [sbck_pkg::DIM_W-1:0] dim);
    logic [sbck_pkg::DIM_W-1:0] dm1;
    dm1 = dim - 1'b1;
    if (dim == '0) begin
      last_index = '0;
    end else if ({1'b0, dim} > (sbck_pkg::DIM_W+1)'(MAX_SPRITE_DIM)) begin
      last_index = CW'(MAX_SPRITE_DIM - 1);
    end else begin
      last_index = CW'(dm1);
    end
  endfunction

  logic [sbck_pkg::COLOR_W-1:0] color;
  logic signed [SW-1:0]         sx;
  logic signed [SW-1:0]         sy;
  logic                         visible;
  logic                         we;

  assign color = {pixel.red[7:3], pixel.green[7:2], pixel.blue[7:3]};

  assign sx = SW'(x_origin) + $signed({{(SW-CW){1'b0}}, column_count});
  assign sy = SW'(y_origin) + $signed({{(SW-CW){1'b0}}, row_count});

  assign visible = !sx[SW-1] && (sx < $signed(SW'(SCREEN_COLS)))
                && !sy[SW-1] && (sy < $signed(SW'(SCREEN_ROWS)));
  assign we = visible && (color != key_color);

  assign step.col_last = column_count >= last_index(sprite_width);
  assign step.row_last = row_count >= last_index(sprite_height);

  always_comb begin
    result.write_enable = we;
    result.screen_x     = we ? sx[sbck_pkg::SCR_W-1:0] : '0;
    result.screen_y     = we ? sy[sbck_pkg::SCR_W-1:0] : '0;
    result.pixel_color  = color;
    result.sprite_done  = step.col_last && step.row_last;
  end

endmodule

// File: src/sprite_blit_color_key.sv
// Results are registered; the skid entry holds one if the result output stalls.
// Throughput: one item per cycle; the single compute stage sits between the
// column/row counters and the result register. A skid entry makes the input
// stall a register output, so the result stall never reaches it combinationally;
// the input stalls only while the skid entry is occupied.
// Reset (synchronous, active high): counters to zero, origins 0, width and
// height 1, key color 17289, result and skid entries empty.
module sprite_blit_color_key #(
  parameter int SCREEN_COLS    = 480,
  parameter int SCREEN_ROWS    = 320,
  parameter int MAX_SPRITE_DIM = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [sbck_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sbck_pkg::CFG_W-1:0]   cfg_data,
  // sprite pixel items
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  sbck_pkg::pixel_t             pixel,
  // result items
  output logic                         result_valid,
  input  logic                         result_stall,
  output sbck_pkg::result_t            result
);

  localparam int CW = $clog2(MAX_SPRITE_DIM);

  // Configuration registers
  logic signed [sbck_pkg::COORD_W-1:0] x_origin;
  logic signed [sbck_pkg::COORD_W-1:0] y_origin;
  logic [sbck_pkg::DIM_W-1:0]          sprite_width;
  logic [sbck_pkg::DIM_W-1:0]          sprite_height;
  logic [sbck_pkg::COLOR_W-1:0]        key_color;

  // Walk position inside the sprite: columns outer, rows inner
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;

  // Skid entry holds an item that arrived while the result register was blocked
  logic              skid_valid;
  sbck_pkg::result_t skid;

  sbck_pkg::result_t calc;
  sbck_pkg::step_t   step;
  logic              accept;
  logic              take;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin      <= '0;
      y_origin      <= '0;
      sprite_width  <= sbck_pkg::DIM_W'(1);
      sprite_height <= sbck_pkg::DIM_W'(1);
      key_color     <= sbck_pkg::KEY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sbck_pkg::REG_X_ORIGIN:      x_origin      <= cfg_data[sbck_pkg::COORD_W-1:0];
        sbck_pkg::REG_Y_ORIGIN:      y_origin      <= cfg_data[sbck_pkg::COORD_W-1:0];
        sbck_pkg::REG_SPRITE_WIDTH:  sprite_width  <= cfg_data[sbck_pkg::DIM_W-1:0];
        sbck_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg_data[sbck_pkg::DIM_W-1:0];
        sbck_pkg::REG_KEY_COLOR:     key_color     <= cfg_data[sbck_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Convert, place, clip and key one pixel; also flag the last row and column.
  sbck_pixel #(
    .SCREEN_COLS    (SCREEN_COLS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_pixel (
    .pixel         (pixel),
    .x_origin      (x_origin),
    .y_origin      (y_origin),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .key_color     (key_color),
    .column_count  (column_count),
    .row_count     (row_count),
    .result        (calc),
    .step          (step)
  );

  // Stall upstream only while the skid entry is occupied (registered signal).
  assign pixel_stall = skid_valid;
  assign accept      = pixel_valid && !skid_valid;
  assign take        = result_valid && !result_stall;

  // Advance the counters once per accepted item; wrap rows first, then columns.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (step.row_last) begin
        row_count    <= '0;
        column_count <= step.col_last ? '0 : column_count + 1'b1;
      end else begin
        row_count <= row_count + 1'b1;
      end
    end
  end

  // Result register and skid entry control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (accept) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      // drain the skid entry into the result register, or go empty
      result_valid <= skid_valid;
      skid_valid   <= 1'b0;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!result_valid || take) begin
        result <= calc;
      end else begin
        skid <= calc;
      end
    end else if (take && skid_valid) begin
      result <= skid;
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_COLS = 480;
  localparam int SCREEN_ROWS = 320;
  localparam int MAX_DIM     = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 8;
  localparam int PRINT_CAP   = 200;
  localparam int PHASE_ITEMS = 165;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [sbck_pkg::IDX_W-1:0] UNMAPPED_REG = '1;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       cfg_we       = 1'b0;
  logic [sbck_pkg::IDX_W-1:0] cfg_index    = '0;
  logic [sbck_pkg::CFG_W-1:0] cfg_data     = '0;
  logic                       pixel_valid  = 1'b0;
  logic                       pixel_stall;
  sbck_pkg::pixel_t           pixel        = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  sbck_pkg::result_t          result;

  sprite_blit_color_key dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #10 clk = ~clk;

  // Shadow copy of the register file and the sprite walk counters.
  logic signed [sbck_pkg::COORD_W-1:0] x_org   = '0;
  logic signed [sbck_pkg::COORD_W-1:0] y_org   = '0;
  logic [sbck_pkg::DIM_W-1:0]          spr_w   = 10'd1;
  logic [sbck_pkg::DIM_W-1:0]          spr_h   = 10'd1;
  logic [sbck_pkg::COLOR_W-1:0]        key     = sbck_pkg::KEY_RESET;
  logic [8:0]                          col_cnt = '0;
  logic [8:0]                          row_cnt = '0;

  sbck_pkg::pixel_t  pixel_queue[$];   // items waiting for the driver
  sbck_pkg::result_t results_due[$];   // frame buffer writes predicted, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int cycles         = 0;

  task automatic flag_error(string msg);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("ERROR cycle %0d: %s", cycles, msg);
    end
  endtask

  // Zero acts as one, anything past the maximum acts as the maximum.
  function automatic int clamp_dim(logic [sbck_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Predict the write for one accepted pixel, then advance the walk:
  // top to bottom within a column, then the next column, then wrap.
  function automatic void blit_pixel(sbck_pkg::pixel_t p);
    int                           w, h, sx, sy;
    logic [sbck_pkg::COLOR_W-1:0] color;
    logic                         row_last, col_last, we;
    sbck_pkg::result_t            r;
    w        = clamp_dim(spr_w);
    h        = clamp_dim(spr_h);
    color    = {p.red[7:3], p.green[7:2], p.blue[7:3]};
    sx       = int'(x_org) + int'(col_cnt);
    sy       = int'(y_org) + int'(row_cnt);
    we       = sx >= 0 && sx < SCREEN_COLS && sy >= 0 && sy < SCREEN_ROWS && color != key;
    // A counter past a shrunken last index counts as last.
    row_last = int'(row_cnt) >= h - 1;
    col_last = int'(col_cnt) >= w - 1;
    r.write_enable = we;
    r.screen_x     = we ? sbck_pkg::SCR_W'(sx) : '0;
    r.screen_y     = we ? sbck_pkg::SCR_W'(sy) : '0;
    r.pixel_color  = color;
    r.sprite_done  = row_last && col_last;
    results_due.push_back(r);
    if (row_last) begin
      row_cnt = '0;
      col_cnt = col_last ? '0 : col_cnt + 1'b1;
    end else begin
      row_cnt = row_cnt + 1'b1;
    end
  endfunction

  // Pixel driver: predict on acceptance, hold a stalled item, and pull the
  // next one from the queue unless this cycle is rolled as idle.
  always @(posedge clk) begin
    logic take;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      take = pixel_valid && !pixel_stall;
      if (take) begin
        blit_pixel(pixel);
      end
      if (!pixel_valid || take) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel       <= pixel_queue.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction,
  // then roll the stall for the next cycle.
  always @(posedge clk) begin
    sbck_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (results_due.size() == 0) begin
          flag_error("result arrived with no write due");
        end else begin
          want = results_due.pop_front();
          if (result.write_enable !== want.write_enable)
            flag_error($sformatf("write_enable got %0b want %0b",
                                 result.write_enable, want.write_enable));
          if (result.screen_x !== want.screen_x)
            flag_error($sformatf("screen_x got %0d want %0d",
                                 result.screen_x, want.screen_x));
          if (result.screen_y !== want.screen_y)
            flag_error($sformatf("screen_y got %0d want %0d",
                                 result.screen_y, want.screen_y));
          if (result.pixel_color !== want.pixel_color)
            flag_error($sformatf("pixel_color got %04h want %04h",
                                 result.pixel_color, want.pixel_color));
          if (result.sprite_done !== want.sprite_done)
            flag_error($sformatf("sprite_done got %0b want %0b",
                                 result.sprite_done, want.sprite_done));
        end
      end
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Write one register while the block is idle; track it in the shadow copy.
  task automatic write_reg(logic [sbck_pkg::IDX_W-1:0] idx,
                           logic [sbck_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      sbck_pkg::REG_X_ORIGIN:      x_org = data[sbck_pkg::COORD_W-1:0];
      sbck_pkg::REG_Y_ORIGIN:      y_org = data[sbck_pkg::COORD_W-1:0];
      sbck_pkg::REG_SPRITE_WIDTH:  spr_w = data[sbck_pkg::DIM_W-1:0];
      sbck_pkg::REG_SPRITE_HEIGHT: spr_h = data[sbck_pkg::DIM_W-1:0];
      sbck_pkg::REG_KEY_COLOR:     key   = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Hold until every queued pixel is taken and every write has come out.
  task automatic drain();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pixel_valid || results_due.size() != 0);
  endtask

  task automatic send_random(int n);
    repeat (n) pixel_queue.push_back(sbck_pkg::pixel_t'($urandom));
    drain();
  endtask

  // Near the screen edges, anywhere on or off screen, or at the extremes.
  function automatic logic [sbck_pkg::COORD_W-1:0] pick_origin(int span);
    int v;
    case ($urandom_range(4))
      0:       v = int'($urandom_range(2047)) - 1024;
      1:       v = int'($urandom_range(20)) - 10;
      2:       v = span - 12 + int'($urandom_range(16));
      3:       v = $urandom_range(1) ? -1024 : 1023;
      default: v = int'($urandom_range(span - 1));
    endcase
    return sbck_pkg::COORD_W'(v);
  endfunction

  // Mostly tiny sprites; zero, the maximum and oversized now and then.
  function automatic logic [sbck_pkg::DIM_W-1:0] pick_dim();
    case ($urandom_range(15))
      0:       return '0;
      1:       return sbck_pkg::DIM_W'($urandom_range(1023, MAX_DIM + 1));
      2:       return sbck_pkg::DIM_W'(MAX_DIM);
      3, 4:    return sbck_pkg::DIM_W'($urandom_range(16, 1));
      default: return sbck_pkg::DIM_W'($urandom_range(5, 1));
    endcase
  endfunction

  // Random sprites: reprogram, then stream whole sprites (several of the same
  // shape back to back) or a broken partial run that leaves the walk mid-sprite.
  task automatic random_sprites(int budget);
    int                           sent, n, w, h;
    sbck_pkg::pixel_t             palette[4];
    sbck_pkg::pixel_t             p;
    logic [sbck_pkg::DIM_W-1:0]   dim_w, dim_h;
    logic [sbck_pkg::COLOR_W-1:0] key_pick;
    sent = 0;
    while (sent < budget) begin
      foreach (palette[i]) palette[i] = sbck_pkg::pixel_t'($urandom);
      dim_w = pick_dim();
      dim_h = pick_dim();
      w     = clamp_dim(dim_w);
      h     = clamp_dim(dim_h);
      // Upper data bits are junk; the register keeps only its own width.
      write_reg(sbck_pkg::REG_X_ORIGIN, {5'($urandom), pick_origin(SCREEN_COLS)});
      write_reg(sbck_pkg::REG_Y_ORIGIN, {5'($urandom), pick_origin(SCREEN_ROWS)});
      write_reg(sbck_pkg::REG_SPRITE_WIDTH, {6'($urandom), dim_w});
      write_reg(sbck_pkg::REG_SPRITE_HEIGHT, {6'($urandom), dim_h});
      // Key on the first palette color half the time, so keyed pixels occur.
      key_pick = $urandom_range(1) ?
                 {palette[0].red[7:3], palette[0].green[7:2], palette[0].blue[7:3]} :
                 sbck_pkg::COLOR_W'($urandom);
      write_reg(sbck_pkg::REG_KEY_COLOR, key_pick);
      if ($urandom_range(19) == 0) begin
        write_reg(UNMAPPED_REG, sbck_pkg::CFG_W'($urandom));
      end
      if (w * h > 64 || $urandom_range(7) == 0) begin
        n = $urandom_range(40, 1);
      end else begin
        n = $urandom_range(3, 1) * w * h;
      end
      repeat (n) begin
        p = palette[$urandom_range(3)];
        if ($urandom_range(2) == 0) begin
          p = sbck_pkg::pixel_t'($urandom);
        end else begin
          // Vary the bits that the RGB565 packing drops.
          p.red[2:0]   = 3'($urandom);
          p.green[1:0] = 2'($urandom);
          p.blue[2:0]  = 3'($urandom);
        end
        pixel_queue.push_back(p);
      end
      drain();
      sent += n;
    end
  endtask

  initial begin
    int phase_idle[4]  = '{0, 72, 0, 22};
    int phase_stall[4] = '{0, 0, 72, 22};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset key color, once exact and once through the dropped low bits;
    // then the component extremes.
    pixel_queue.push_back(sbck_pkg::pixel_t'{8'd64, 8'd112, 8'd72});
    pixel_queue.push_back(sbck_pkg::pixel_t'{8'd71, 8'd115, 8'd79});
    pixel_queue.push_back(sbck_pkg::pixel_t'{8'h00, 8'h00, 8'h00});
    pixel_queue.push_back(sbck_pkg::pixel_t'{8'hff, 8'hff, 8'hff});
    drain();

    // Origin extremes, and the last visible screen corner.
    write_reg(sbck_pkg::REG_X_ORIGIN, 16'(-1024));
    write_reg(sbck_pkg::REG_Y_ORIGIN, 16'(1023));
    send_random(1);
    write_reg(sbck_pkg::REG_X_ORIGIN, 16'(1023));
    write_reg(sbck_pkg::REG_Y_ORIGIN, 16'(-1024));
    send_random(1);
    write_reg(sbck_pkg::REG_X_ORIGIN, 16'(SCREEN_COLS - 1));
    write_reg(sbck_pkg::REG_Y_ORIGIN, 16'(SCREEN_ROWS - 1));
    send_random(1);

    // Key extremes: black keyed out, then white keyed out.
    write_reg(sbck_pkg::REG_X_ORIGIN, '0);
    write_reg(sbck_pkg::REG_Y_ORIGIN, '0);
    write_reg(sbck_pkg::REG_KEY_COLOR, '0);
    pixel_queue.push_back(sbck_pkg::pixel_t'{8'h00, 8'h00, 8'h00});
    pixel_queue.push_back(sbck_pkg::pixel_t'{8'hff, 8'hff, 8'hff});
    drain();
    write_reg(sbck_pkg::REG_KEY_COLOR, '1);
    pixel_queue.push_back(sbck_pkg::pixel_t'{8'hff, 8'hff, 8'hff});
    drain();

    // Zero dimensions behave as one: every pixel ends a sprite.
    write_reg(sbck_pkg::REG_SPRITE_WIDTH, '0);
    write_reg(sbck_pkg::REG_SPRITE_HEIGHT, '0);
    send_random(2);

    // Clip on the right and bottom edges, then on the left and top.
    write_reg(sbck_pkg::REG_SPRITE_WIDTH, 16'd2);
    write_reg(sbck_pkg::REG_SPRITE_HEIGHT, 16'd2);
    write_reg(sbck_pkg::REG_X_ORIGIN, 16'(SCREEN_COLS - 1));
    write_reg(sbck_pkg::REG_Y_ORIGIN, 16'(SCREEN_ROWS - 1));
    send_random(4);
    write_reg(sbck_pkg::REG_X_ORIGIN, 16'(-1));
    write_reg(sbck_pkg::REG_Y_ORIGIN, 16'(-1));
    send_random(4);

    // Oversized dimensions, then shrink mid-sprite twice.
    write_reg(sbck_pkg::REG_SPRITE_WIDTH, 16'd1023);
    write_reg(sbck_pkg::REG_SPRITE_HEIGHT, 16'd1023);
    send_random(3);
    write_reg(sbck_pkg::REG_SPRITE_WIDTH, 16'd3);
    write_reg(sbck_pkg::REG_SPRITE_HEIGHT, 16'd2);
    send_random(2);
    write_reg(sbck_pkg::REG_SPRITE_WIDTH, 16'd1);
    write_reg(sbck_pkg::REG_SPRITE_HEIGHT, 16'd1);
    send_random(2);

    // Random sprites under each idling mix.
    for (int i = 0; i < 4; i++) begin
      send_idle_pct  = phase_idle[i];
      recv_stall_pct = phase_stall[i];
      random_sprites(PHASE_ITEMS);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      flag_error($sformatf("%0d writes never came out", results_due.size()));
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sprite_blit_color_key.f
src/sbck_pkg.sv
src/sbck_pixel.sv
src/sprite_blit_color_key.sv
tb/testbench.sv
